// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pese_pkg.sv =====
// ----------------------------------------------------------------------------
// pese_pkg
// types, codes and constants of the prefix expression stack evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pese_pkg;

  localparam int DATA_W           = 32;
  localparam int PESE_STACK_DEPTH = 16;

  localparam logic [2:0] OP_OPERAND = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_SUB     = 3'd2;
  localparam logic [2:0] OP_MUL     = 3'd3;
  localparam logic [2:0] OP_DIV     = 3'd4;
  localparam logic [2:0] OP_INVALID = 3'd5;
  localparam logic [2:0] OP_END     = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_LEFTOVER  = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;
  localparam logic [2:0] ST_DIVZERO   = 3'd5;
  localparam logic [2:0] ST_OVERFLOW  = 3'd6;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [30:0] operand_value;
  } pese_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } pese_out_t;

  // controller to datapath
  typedef struct packed {
    logic       push;
    logic       rd;
    logic       alu_wr;
    logic [2:0] alu_op;
    logic       div_start;
    logic       div_wr;
    logic       set_err;
    logic [2:0] err_code;
    logic       finish;
  } pese_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic lt2;
    logic err_set;
    logic rhs_zero;
    logic div_done;
    logic out_busy;
  } pese_stat_t;

endpackage

// ===== rtl/core/pese_ram.sv =====
// ----------------------------------------------------------------------------
// pese_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pese_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/pese_div.sv =====
// ----------------------------------------------------------------------------
// pese_div
// iterative signed divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pese_div import pese_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] div_r, div_nxt;
  logic              neg_r, neg_nxt;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              ge;

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign ge      = shifted >= {1'b0, div_r};
  assign diff    = shifted - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
      div_nxt  = divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
      neg_nxt  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + DATA_W'(1)) : quo_r;

endmodule

// ===== rtl/core/pese_dpath.sv =====
// ----------------------------------------------------------------------------
// pese_dpath
// operand stack, top-of-stack register, alu, divider and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pese_dpath import pese_pkg::*; #(
  parameter int STACK_DEPTH = PESE_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pese_cmd_t   cmd,
  input  logic [30:0] operand_value,
  input  logic        out_stall,
  output pese_stat_t  stat,
  output logic        out_valid,
  output pese_out_t   out_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [CW-1:0]     count_r, count_nxt;
  logic [2:0]        err_r, err_nxt;
  logic [DATA_W-1:0] tos_r, tos_nxt;
  logic              out_valid_r, out_valid_nxt;
  pese_out_t         out_data_r, out_data_nxt;

  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic [DATA_W-1:0] rhs;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] div_q;
  logic              div_done;

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);

  pese_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH),
    .ADDR_W(AW)
  ) u_stack (
    .clk  (clk),
    .we   (cmd.push && (count_r != '0)),
    .waddr(cnt_m1[AW-1:0]),
    .wdata(tos_r),
    .re   (cmd.rd),
    .raddr(cnt_m2[AW-1:0]),
    .rdata(rhs)
  );

  pese_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(tos_r),
    .divisor (rhs),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    case (cmd.alu_op)
      OP_ADD:  alu_res = tos_r + rhs;
      OP_SUB:  alu_res = tos_r - rhs;
      default: alu_res = tos_r * rhs;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    err_nxt       = err_r;
    tos_nxt       = tos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (cmd.push) begin
      tos_nxt   = {1'b0, operand_value};
      count_nxt = count_r + CW'(1);
    end
    if (cmd.alu_wr) begin
      tos_nxt   = alu_res;
      count_nxt = cnt_m1;
    end
    if (cmd.div_wr) begin
      tos_nxt   = div_q;
      count_nxt = cnt_m1;
    end
    if (cmd.set_err) begin
      err_nxt = cmd.err_code;
    end
    if (cmd.finish) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.result_value = '0;
      if (err_r != ST_OK) begin
        out_data_nxt.status = err_r;
      end else if (count_r == '0) begin
        out_data_nxt.status = ST_EMPTY;
      end else if (count_r != CW'(1)) begin
        out_data_nxt.status = ST_LEFTOVER;
      end else begin
        out_data_nxt.status       = ST_OK;
        out_data_nxt.result_value = tos_r;
      end
      count_nxt = '0;
      err_nxt   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tos_r      <= tos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign stat.full     = count_r == CW'(STACK_DEPTH);
  assign stat.lt2      = count_r < CW'(2);
  assign stat.err_set  = err_r != ST_OK;
  assign stat.rhs_zero = rhs == '0;
  assign stat.div_done = div_done;
  assign stat.out_busy = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/pese_ctrl.sv =====
// ----------------------------------------------------------------------------
// pese_ctrl
// token sequencer: decodes each transfer and steps the datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pese_ctrl import pese_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] opcode,
  input  pese_stat_t stat,
  output logic       in_stall,
  output pese_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE) || stat.out_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.alu_op = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_END) begin
            cmd.finish = 1'b1;
          end else if (!stat.err_set) begin
            case (opcode) inside
              OP_OPERAND: begin
                if (stat.full) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_OVERFLOW;
                end else begin
                  cmd.push = 1'b1;
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (stat.lt2) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_UNDERFLOW;
                end else begin
                  cmd.rd    = 1'b1;
                  op_nxt    = opcode;
                  state_nxt = S_EXEC;
                end
              end
              default: begin
                cmd.set_err  = 1'b1;
                cmd.err_code = ST_INVALID;
              end
            endcase
          end
        end
      end
      S_EXEC: begin
        if (op_r == OP_DIV) begin
          if (stat.rhs_zero) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_DIVZERO;
            state_nxt    = S_IDLE;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else begin
          cmd.alu_wr = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_wr = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r <= op_nxt;
  end

endmodule

// ===== rtl/core/prefix_expression_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// prefix_expression_stack_evaluator
// evaluates prefix expression tokens, fed right to left, on an operand stack
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    pese_in_t  (opcode, operand_value)
//   out_     output     out_valid/out_stall  pese_out_t (result_value, status)
//
// operand, end, error and ignored tokens: taken in the idle state
// add, subtract, multiply: stack memory read, then alu
// divide: stack memory read, zero check, then the one-bit-per-cycle divider (32 steps)
// synchronous active-low reset clears count, error and handshake state
// a held result blocks new input only while out_stall is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prefix_expression_stack_evaluator import pese_pkg::*; #(
  parameter int STACK_DEPTH = PESE_STACK_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pese_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output pese_out_t out_data
);

  pese_cmd_t  cmd;
  pese_stat_t stat;
  logic       in_end_xfer;

  pese_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .opcode  (in_data.opcode),
    .stat    (stat),
    .in_stall(in_stall),
    .cmd     (cmd)
  );

  pese_dpath #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .operand_value(in_data.operand_value),
    .out_stall    (out_stall),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

  assign in_end_xfer = in_valid && !in_stall && (in_data.opcode == OP_END);

  // end token transfer always produces a result next cycle
  `ASSERT_NEXT(a_end_gives_out, in_end_xfer, out_valid, "end token without result")
  // a new result only follows an end token transfer
  `ASSERT_IMPL(a_out_from_end, $rose(out_valid), $past(in_end_xfer), "result without end token")
  // operator in flight holds off input
  `ASSERT_NEXT(a_busy_stalls, cmd.rd || cmd.div_start, in_stall, "input accepted during operator")

endmodule

// ===== verif/prefix_expression_stack_evaluator_tb.sv =====
// ----------------------------------------------------------------------------
// prefix_expression_stack_evaluator_tb
// self-checking bench for the prefix expression stack evaluator: feeds
// directed corner expressions, then random well-formed, broken, noisy and deep
// token streams with idle and stall bursts on both channels, and checks
// every result against an in-bench model of the operand stack
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prefix_expression_stack_evaluator_tb;
  import pese_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_START  = 900;
  localparam int TOKEN_GOAL  = 1050;

  class expr_eval_scoreboard;
    logic [31:0] held_values [PESE_STACK_DEPTH];
    int unsigned depth;
    logic [2:0]  first_error;
    pese_out_t   awaited_answers [$];
    int          failures;
    int          live_tokens;
    int          answers_checked;
    int          status_hits [8];

    function new();
      depth = 0;
      first_error = ST_OK;
      failures = 0;
      live_tokens = 0;
      answers_checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function int pending();
      return awaited_answers.size();
    endfunction

    function logic [31:0] trunc_quotient(logic [31:0] num, logic [31:0] den);
      logic [31:0] mag_n, mag_d, q;
      mag_n = num[31] ? -num : num;
      mag_d = den[31] ? -den : den;
      q = mag_n / mag_d;
      return (num[31] ^ den[31]) ? -q : q;
    endfunction

    // called once per input transfer
    function void apply_token(pese_in_t tok);
      pese_out_t   ans;
      logic [31:0] lhs, rhs, res;
      if (tok.opcode == OP_END) begin
        live_tokens++;
        ans.result_value = '0;
        if (first_error != ST_OK) begin
          ans.status = first_error;
        end else if (depth == 0) begin
          ans.status = ST_EMPTY;
        end else if (depth > 1) begin
          ans.status = ST_LEFTOVER;
        end else begin
          ans.status = ST_OK;
          ans.result_value = held_values[0];
        end
        awaited_answers.push_back(ans);
        status_hits[ans.status]++;
        depth = 0;
        first_error = ST_OK;
        return;
      end
      // sticky error: everything up to the end token is dropped
      if (first_error != ST_OK) return;
      live_tokens++;
      case (tok.opcode)
        OP_OPERAND: begin
          if (depth >= PESE_STACK_DEPTH) begin
            first_error = ST_OVERFLOW;
          end else begin
            held_values[depth] = {1'b0, tok.operand_value};
            depth++;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (depth < 2) begin
            first_error = ST_UNDERFLOW;
          end else begin
            lhs = held_values[depth - 1];
            rhs = held_values[depth - 2];
            if (tok.opcode == OP_DIV && rhs == '0) begin
              first_error = ST_DIVZERO;
            end else begin
              case (tok.opcode)
                OP_ADD:  res = lhs + rhs;
                OP_SUB:  res = lhs - rhs;
                OP_MUL:  res = lhs * rhs;
                default: res = trunc_quotient(lhs, rhs);
              endcase
              depth--;
              held_values[depth - 1] = res;
            end
          end
        end
        default: first_error = ST_INVALID;
      endcase
    endfunction

    // called once per result transfer
    function void check_answer(pese_out_t got);
      pese_out_t want;
      if (awaited_answers.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                 $time, got.result_value, got.status);
        return;
      end
      want = awaited_answers.pop_front();
      answers_checked++;
      if (got.status !== want.status) begin
        failures++;
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, got.status);
      end
      if (got.result_value !== want.result_value) begin
        failures++;
        $display("%0t: result_value mismatch, expected %0d actual %0d",
                 $time, want.result_value, got.result_value);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  pese_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pese_out_t out_data;

  expr_eval_scoreboard sb = new();
  pese_in_t batch [$];
  bit sender_idles = 1'b0;
  bit receiver_idles = 1'b0;
  int quiet_cycles = 0;
  int tokens_sent = 0;

  always #5 clk = ~clk;

  prefix_expression_stack_evaluator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  function automatic pese_in_t make_token(logic [2:0] op, logic [30:0] val);
    pese_in_t t;
    t.opcode = op;
    t.operand_value = val;
    return t;
  endfunction

  function automatic logic [30:0] pick_literal();
    case ($urandom_range(0, 5))
      0:       return 31'($urandom_range(0, 1));
      1, 2:    return 31'($urandom_range(1, 12));
      3:       return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_arith_op();
    case ($urandom_range(0, 3))
      0:       return OP_ADD;
      1:       return OP_SUB;
      2:       return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  task automatic send_token(pese_in_t tok);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tok;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.apply_token(tok);
    tokens_sent++;
  endtask

  task automatic send_batch();
    foreach (batch[i]) send_token(batch[i]);
    batch.delete();
  endtask

  task automatic wait_all_answered();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // random-length expression that always reduces to a single value
  task automatic queue_wellformed();
    int pushes_left;
    int level;
    pushes_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, PESE_STACK_DEPTH)
                                               : $urandom_range(1, 6);
    level = 0;
    while (pushes_left > 0 || level > 1) begin
      if (level >= 2 && (pushes_left == 0 || $urandom_range(0, 1) == 0)) begin
        batch.push_back(make_token(pick_arith_op(), 31'($urandom)));
        level--;
      end else begin
        batch.push_back(make_token(OP_OPERAND, pick_literal()));
        pushes_left--;
        level++;
      end
    end
    batch.push_back(make_token(OP_END, 31'($urandom)));
  endtask

  task automatic queue_broken();
    int pos;
    queue_wellformed();
    pos = $urandom_range(0, batch.size() - 2);
    if ($urandom_range(0, 1) == 0) begin
      batch.delete(pos);
    end else begin
      batch.insert(pos, make_token(pick_arith_op(), 31'($urandom)));
    end
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(1, 20)) begin
      if ($urandom_range(0, 9) < 5) begin
        batch.push_back(make_token(OP_OPERAND, pick_literal()));
      end else begin
        batch.push_back(make_token(3'($urandom_range(1, 7)), 31'($urandom)));
      end
    end
    batch.push_back(make_token(OP_END, 31'($urandom)));
  endtask

  task automatic queue_deep();
    repeat (PESE_STACK_DEPTH + $urandom_range(0, 3)) begin
      batch.push_back(make_token(OP_OPERAND, pick_literal()));
    end
    repeat ($urandom_range(0, 3)) batch.push_back(make_token(pick_arith_op(), 31'($urandom)));
    batch.push_back(make_token(OP_END, 31'($urandom)));
  endtask

  // result side: random stall bursts
  initial begin : stall_gen
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        if (receiver_idles && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 18);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) sb.check_answer(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int  roll;
    bit  tail;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    // empty expression
    batch.push_back(make_token(OP_END, 31'h0));
    // most negative value divided by minus one
    batch.push_back(make_token(OP_OPERAND, 31'd1));
    batch.push_back(make_token(OP_OPERAND, 31'd0));
    batch.push_back(make_token(OP_SUB, 31'h7FFF_FFFF));
    batch.push_back(make_token(OP_OPERAND, 31'd2));
    batch.push_back(make_token(OP_OPERAND, 31'h4000_0000));
    batch.push_back(make_token(OP_MUL, 31'h0));
    batch.push_back(make_token(OP_DIV, 31'h5555_5555));
    batch.push_back(make_token(OP_END, 31'h2AAA_AAAA));
    // divide by zero
    batch.push_back(make_token(OP_OPERAND, 31'd0));
    batch.push_back(make_token(OP_OPERAND, 31'h7FFF_FFFF));
    batch.push_back(make_token(OP_DIV, 31'h0));
    batch.push_back(make_token(OP_END, 31'h0));
    // underflow on a single operand, then end
    batch.push_back(make_token(OP_OPERAND, 31'd3));
    batch.push_back(make_token(OP_ADD, 31'h0));
    batch.push_back(make_token(OP_END, 31'h0));
    // leftover operands
    batch.push_back(make_token(OP_OPERAND, 31'd7));
    batch.push_back(make_token(OP_OPERAND, 31'd7));
    batch.push_back(make_token(OP_END, 31'h0));
    // invalid character and unused opcode
    batch.push_back(make_token(OP_INVALID, 31'h7FFF_FFFF));
    batch.push_back(make_token(OP_END, 31'h0));
    batch.push_back(make_token(3'd7, 31'h0));
    batch.push_back(make_token(OP_OPERAND, 31'd1));
    batch.push_back(make_token(OP_END, 31'h0));
    send_batch();

    // hold off until the evaluator has drained
    in_valid <= 1'b0;
    wait_all_answered();

    while (tokens_sent < TOKEN_GOAL) begin
      tail = (tokens_sent > TAIL_START);
      sender_idles = !tail && $urandom_range(0, 2) != 0;
      receiver_idles = !tail && $urandom_range(0, 2) != 0;
      roll = $urandom_range(0, 19);
      if (roll < 14) begin
        queue_wellformed();
      end else if (roll < 17) begin
        queue_broken();
      end else if (roll < 19) begin
        queue_noise();
      end else begin
        queue_deep();
      end
      send_batch();
      if (!tail && $urandom_range(0, 39) == 0) begin
        in_valid <= 1'b0;
        wait_all_answered();
      end
    end
    in_valid <= 1'b0;
    receiver_idles = 1'b0;
    wait_all_answered();
    repeat (40) @(posedge clk);

    $display("covered %0d tokens (%0d live) and %0d results: ok %0d, empty %0d, leftover %0d",
             tokens_sent, sb.live_tokens, sb.answers_checked, sb.status_hits[ST_OK],
             sb.status_hits[ST_EMPTY], sb.status_hits[ST_LEFTOVER]);
    $display("error results: underflow %0d, invalid %0d, divide by zero %0d, overflow %0d",
             sb.status_hits[ST_UNDERFLOW], sb.status_hits[ST_INVALID],
             sb.status_hits[ST_DIVZERO], sb.status_hits[ST_OVERFLOW]);
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
